// File: hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock outside of reset
`define GVD_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// signal holds for the next cycle whenever the condition is true
`define GVD_ASSERT_HOLD(name, cond, sig, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) cond |=> $stable(sig)) else $error(msg);

`endif

// File: hdl/gvd_pkg.sv
// types and constants shared by the grid volume difference modules
package gvd_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int LINE_LEN_W = 11;
	localparam int LINE_CNT_W = 16;
	localparam int SAMPLE_W   = 32;
	localparam int CNT_W      = 32;
	localparam int MAG_W      = 34;

	localparam logic [CFG_IDX_W-1:0] REG_Z_OFFSET    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_C_OFFSET    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_AREA   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT  = 3'd4;

	localparam logic [62:0] POS_CAP = 63'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] NEG_CAP = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic             valid;
		logic             counted;
		logic             defined;
		logic             grid_end;
		logic             neg;
		logic [MAG_W-1:0] mag;
	} sq_t;

	typedef struct packed {
		logic [62:0]        volume_positive;
		logic signed [63:0] volume_negative;
		logic signed [63:0] volume_total;
		logic [CNT_W-1:0]   squares_defined;
		logic [CNT_W-1:0]   squares_total;
	} res_t;

endpackage

// File: hdl/gvd_ram.sv
// generic ram, one write port and two registered read ports
module gvd_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// File: hdl/gvd_acc.sv
// square volume multiply, saturation and accumulation of the grid sums
module gvd_acc import gvd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [CFG_DATA_W-1:0] cell_area,
	input  sq_t                   sq_in,
	output logic                  res_valid,
	output res_t                  res
);

	sq_t sq_s3;

	logic [63:0] p_lo;
	logic [33:0] p_hi;

	logic        v_s4, counted_s4, defined_s4, grid_end_s4, neg_s4;
	logic [63:0] p_lo_s4;
	logic [33:0] p_hi_s4;

	logic [34:0] hi_sum;
	logic [63:0] mag64;

	logic        v_s5, counted_s5, defined_s5, grid_end_s5, neg_s5;
	logic [63:0] mag_s5;

	logic             emit_q;
	logic [62:0]      sum_pos_q, base_pos, nxt_pos, pos_add;
	logic [63:0]      sum_neg_q, base_neg, nxt_neg;
	logic [CNT_W-1:0] cnt_def_q, base_def, nxt_def;
	logic [CNT_W-1:0] cnt_tot_q, base_tot, nxt_tot;

	// stage 3: partial products of magnitude and cell area
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_s3 <= '0;
		end else begin
			sq_s3 <= sq_in;
		end
	end

	assign p_lo = 64'(sq_s3.mag[31:0]) * 64'(cell_area);
	assign p_hi = 34'(sq_s3.mag[MAG_W-1:32]) * 34'(cell_area);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= sq_s3.valid;
		end
	end

	always_ff @(posedge clk) begin
		counted_s4  <= sq_s3.counted;
		defined_s4  <= sq_s3.defined;
		grid_end_s4 <= sq_s3.grid_end;
		neg_s4      <= sq_s3.neg;
		p_lo_s4     <= p_lo;
		p_hi_s4     <= p_hi;
	end

	// stage 4: combine and clip to the signed 64-bit range
	assign hi_sum = 35'(p_hi_s4) + 35'(p_lo_s4[63:32]);
	assign mag64  = (hi_sum >= 35'h0_8000_0000) ? NEG_CAP : {hi_sum[31:0], p_lo_s4[31:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		counted_s5  <= counted_s4;
		defined_s5  <= defined_s4;
		grid_end_s5 <= grid_end_s4;
		neg_s5      <= neg_s4;
		mag_s5      <= mag64;
	end

	// stage 5: saturating sums, restarted right after a grid is emitted
	always_comb begin
		base_pos = emit_q ? '0 : sum_pos_q;
		base_neg = emit_q ? '0 : sum_neg_q;
		base_def = emit_q ? '0 : cnt_def_q;
		base_tot = emit_q ? '0 : cnt_tot_q;
		nxt_pos  = base_pos;
		nxt_neg  = base_neg;
		nxt_def  = base_def;
		nxt_tot  = base_tot;
		pos_add  = (mag_s5 > 64'(POS_CAP)) ? POS_CAP : mag_s5[62:0];
		if (counted_s5) begin
			if (base_tot != '1) begin
				nxt_tot = base_tot + CNT_W'(1);
			end
			if (defined_s5) begin
				if (base_def != '1) begin
					nxt_def = base_def + CNT_W'(1);
				end
				if (neg_s5 && (mag_s5 != '0)) begin
					nxt_neg = (mag_s5 >= (NEG_CAP - base_neg)) ? NEG_CAP : base_neg + mag_s5;
				end else begin
					nxt_pos = (pos_add >= (POS_CAP - base_pos)) ? POS_CAP : base_pos + pos_add;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_pos_q <= '0;
			sum_neg_q <= '0;
			cnt_def_q <= '0;
			cnt_tot_q <= '0;
			emit_q    <= 1'b0;
		end else begin
			emit_q <= v_s5 && grid_end_s5;
			if (v_s5) begin
				sum_pos_q <= nxt_pos;
				sum_neg_q <= nxt_neg;
				cnt_def_q <= nxt_def;
				cnt_tot_q <= nxt_tot;
			end else if (emit_q) begin
				sum_pos_q <= '0;
				sum_neg_q <= '0;
				cnt_def_q <= '0;
				cnt_tot_q <= '0;
			end
		end
	end

	assign res_valid           = emit_q;
	assign res.volume_positive = sum_pos_q;
	assign res.volume_negative = 64'd0 - sum_neg_q;
	assign res.volume_total    = 64'(sum_pos_q) - sum_neg_q;
	assign res.squares_defined = cnt_def_q;
	assign res.squares_total   = cnt_tot_q;

endmodule

// File: hdl/grid_volume_difference.sv
// top level of the grid volume difference block
//
// channel   direction  handshake              beat contents
// cfg       in         cfg_we                 cfg_index, cfg_data
// in        in         in_valid / in_stall    z_sample, c_sample
// out       out        out_valid / out_stall  volume sums and square counts
//
// one node per cycle while in_stall is low; the line ram is read at two addresses and written once per node
// the grid's result reaches out_valid through stages 1 to 5, the emit register and the result queue
// reset clears control and sums; the line ram has no clearing pass
// in_stall rises only while two grid results are owed and not yet taken downstream
module grid_volume_difference import gvd_pkg::*; #(
	parameter int MAX_LINE = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic signed [31:0]    z_sample,
	input  logic signed [31:0]    c_sample,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [62:0]           volume_positive,
	output logic signed [63:0]    volume_negative,
	output logic signed [63:0]    volume_total,
	output logic [CNT_W-1:0]      squares_defined,
	output logic [CNT_W-1:0]      squares_total
);

	localparam int AW     = $clog2(MAX_LINE);
	localparam int LEN_W0 = $clog2(MAX_LINE + 1);
	localparam int LEN_W  = (LEN_W0 > LINE_LEN_W) ? LEN_W0 : LINE_LEN_W;

	logic signed [31:0]    z_offset_q, c_offset_q;
	logic [CFG_DATA_W-1:0] cell_area_q;
	logic [LINE_LEN_W-1:0] line_length_q;
	logic [LINE_CNT_W-1:0] line_count_q;

	logic [SAMPLE_W-1:0]   prev_z_q, prev_c_q;
	logic [AW-1:0]         node_pos_q, pend_addr_q;
	logic [LINE_CNT_W-1:0] line_pos_q;
	logic [1:0]            owed_q;

	logic                  accept;
	logic [LEN_W-1:0]      len_raw, len_c, np_raw, np;
	logic [LINE_CNT_W-1:0] lines_c;
	logic                  line_end, line_last, grid_end, np_first;
	logic [AW-1:0]         np_addr, waddr;
	logic [2*SAMPLE_W-1:0] rdata_a, rdata_b;

	logic                v_s1, counted_s1, grid_end_s1;
	logic [SAMPLE_W-1:0] z_s1, c_s1, zl_s1, cl_s1;
	logic                def_s1;
	logic [33:0]         sum_z, sum_c;
	logic [32:0]         a_diff, o_diff;

	logic        v_s2, counted_s2, defined_s2, grid_end_s2;
	logic [32:0] a_s2, o_s2;
	logic [34:0] d_s2, abs_s2;
	sq_t         sq_in;

	logic res_valid;
	res_t res;
	res_t fifo_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] fifo_cnt_q;
	logic pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			z_offset_q    <= '0;
			c_offset_q    <= '0;
			cell_area_q   <= '0;
			line_length_q <= LINE_LEN_W'(2);
			line_count_q  <= LINE_CNT_W'(2);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_Z_OFFSET:    z_offset_q    <= cfg_data;
				REG_C_OFFSET:    c_offset_q    <= cfg_data;
				REG_CELL_AREA:   cell_area_q   <= cfg_data;
				REG_LINE_LENGTH: line_length_q <= cfg_data[LINE_LEN_W-1:0];
				REG_LINE_COUNT:  line_count_q  <= cfg_data[LINE_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// node position, line end and grid end of the incoming beat
	assign len_raw = LEN_W'(line_length_q);
	always_comb begin
		len_c = len_raw;
		if (len_raw < LEN_W'(2)) begin
			len_c = LEN_W'(2);
		end else if (len_raw > LEN_W'(MAX_LINE)) begin
			len_c = LEN_W'(MAX_LINE);
		end
	end

	assign np_raw    = LEN_W'(node_pos_q);
	assign np        = (np_raw >= len_c) ? len_c - LEN_W'(1) : np_raw;
	assign np_addr   = np[AW-1:0];
	assign np_first  = (np == '0);
	assign line_end  = (np + LEN_W'(1)) >= len_c;
	assign lines_c   = (line_count_q < LINE_CNT_W'(2)) ? LINE_CNT_W'(2) : line_count_q;
	assign line_last = ({1'b0, line_pos_q} + 17'd1) >= {1'b0, lines_c};
	assign grid_end  = line_end && line_last;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (owed_q == 2'd2);

	// previous node goes back behind the read point; after a line end it lands at the last node
	assign waddr = np_first ? pend_addr_q : np_addr - AW'(1);

	gvd_ram #(
		.WIDTH (2 * SAMPLE_W),
		.DEPTH (MAX_LINE)
	) u_line_ram (
		.clk     (clk),
		.we      (accept),
		.waddr   (waddr),
		.wdata   ({prev_z_q, prev_c_q}),
		.raddr_a (np_addr - AW'(1)),
		.raddr_b (np_addr),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_z_q    <= '0;
			prev_c_q    <= '0;
			node_pos_q  <= '0;
			pend_addr_q <= '0;
			line_pos_q  <= '0;
		end else if (accept) begin
			prev_z_q <= z_sample;
			prev_c_q <= c_sample;
			if (line_end) begin
				node_pos_q  <= '0;
				pend_addr_q <= np_addr;
				line_pos_q  <= grid_end ? '0 : line_pos_q + LINE_CNT_W'(1);
			end else begin
				node_pos_q <= np_addr + AW'(1);
			end
		end
	end

	// stage 1: corners arrive from the line ram
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		counted_s1  <= !np_first && (line_pos_q != '0);
		grid_end_s1 <= grid_end;
		z_s1        <= z_sample;
		c_s1        <= c_sample;
		zl_s1       <= prev_z_q;
		cl_s1       <= prev_c_q;
	end

	assign def_s1 = !(z_s1[31] | c_s1[31] | zl_s1[31] | cl_s1[31] |
		rdata_a[63] | rdata_a[31] | rdata_b[63] | rdata_b[31]);

	assign sum_z = 34'(rdata_a[63:32]) + 34'(rdata_b[63:32]) + 34'(zl_s1) + 34'(z_s1);
	assign sum_c = 34'(rdata_a[31:0]) + 34'(rdata_b[31:0]) + 34'(cl_s1) + 34'(c_s1);

	assign a_diff = {1'b0, sum_c[33:2]} - {1'b0, sum_z[33:2]};
	assign o_diff = {z_offset_q[31], z_offset_q} - {c_offset_q[31], c_offset_q};

	// stage 2: signed difference and its magnitude
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		counted_s2  <= counted_s1;
		defined_s2  <= def_s1;
		grid_end_s2 <= grid_end_s1;
		a_s2        <= a_diff;
		o_s2        <= o_diff;
	end

	assign d_s2   = {{2{a_s2[32]}}, a_s2} + {{2{o_s2[32]}}, o_s2};
	assign abs_s2 = d_s2[34] ? 35'd0 - d_s2 : d_s2;

	always_comb begin
		sq_in.valid    = v_s2;
		sq_in.counted  = counted_s2;
		sq_in.defined  = defined_s2;
		sq_in.grid_end = grid_end_s2;
		sq_in.neg      = d_s2[34];
		sq_in.mag      = abs_s2[MAG_W-1:0];
	end

	gvd_acc u_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.cell_area (cell_area_q),
		.sq_in     (sq_in),
		.res_valid (res_valid),
		.res       (res)
	);

	// two-entry result queue; owed counts grid ends taken but not yet delivered
	assign pop       = out_valid && !out_stall;
	assign out_valid = (fifo_cnt_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= 1'b0;
			rd_ptr_q   <= 1'b0;
			fifo_cnt_q <= 2'd0;
			owed_q     <= 2'd0;
		end else begin
			if (res_valid) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			fifo_cnt_q <= fifo_cnt_q + 2'(res_valid) - 2'(pop);
			owed_q     <= owed_q + 2'(accept && grid_end) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			fifo_q[wr_ptr_q] <= res;
		end
	end

	assign volume_positive = fifo_q[rd_ptr_q].volume_positive;
	assign volume_negative = fifo_q[rd_ptr_q].volume_negative;
	assign volume_total    = fifo_q[rd_ptr_q].volume_total;
	assign squares_defined = fifo_q[rd_ptr_q].squares_defined;
	assign squares_total   = fifo_q[rd_ptr_q].squares_total;

endmodule

// File: hdl/gvd_checker.sv
// port checker for the grid volume difference top level, with its bind
`include "assert_macros.svh"

module gvd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [62:0]        volume_positive,
	input logic signed [63:0] volume_negative,
	input logic signed [63:0] volume_total,
	input logic [31:0]        squares_defined,
	input logic [31:0]        squares_total
);

	`GVD_ASSERT(a_out_valid_hold, out_valid && out_stall |=> out_valid, "out beat dropped while stalled")
	`GVD_ASSERT_HOLD(a_out_total_hold, out_valid && out_stall, volume_total, "stalled total changed")
	`GVD_ASSERT(a_total_sum, out_valid |-> (volume_total == (64'({1'b0, volume_positive}) + volume_negative)), "total is not positive plus negative sum")
	`GVD_ASSERT(a_neg_sign, out_valid |-> (volume_negative[63] || (volume_negative == 64'sd0)), "negative sum above zero")
	`GVD_ASSERT(a_count_order, out_valid |-> (squares_defined <= squares_total), "more defined squares than squares")

endmodule

bind grid_volume_difference gvd_checker u_gvd_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.volume_positive (volume_positive),
	.volume_negative (volume_negative),
	.volume_total    (volume_total),
	.squares_defined (squares_defined),
	.squares_total   (squares_total)
);
